// File: src/kpsq_pkg.sv
package kpsq_pkg;

   localparam int ROW_BITS      = 7;
   localparam int MASK_BITS     = 22;
   localparam int STEPS_BITS    = 16;
   localparam int SENS_BITS     = 8;
   localparam int SCAN_DIV_BITS = 5;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SENS_BITS-1:0] SENS_RESET = 8'd4;

   // action codes
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_BUTTONS = 2'd1;
   localparam logic [1:0] ACT_MOVE    = 2'd2;

   // register index, taken from paddr[2]
   localparam logic REG_SENS = 1'b0;

   localparam logic signed [STEPS_BITS-1:0] STEPS_MAX = 16'sh7FFF;
   localparam logic signed [STEPS_BITS-1:0] STEPS_MIN = 16'sh8000;

   // step per 4-bit phase history {a_old, b_old, a_new, b_new}
   localparam logic signed [1:0] STEP_LUT [16] = '{
      2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1,
      2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd0
   };

   typedef struct packed {
      logic [1:0]          action;
      logic [ROW_BITS-1:0] row1_levels;
      logic [ROW_BITS-1:0] row2_levels;
      logic [ROW_BITS-1:0] row3_levels;
      logic                knob_switch_level;
      logic                phase_a;
      logic                phase_b;
   } req_word_type;

   typedef struct packed {
      logic [MASK_BITS-1:0]         pressed_mask;
      logic signed [STEPS_BITS-1:0] movement_steps;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULT,
      ST_SUB,
      ST_EMIT
   } state_type;

endpackage

// File: src/kpsq_scan.sv
module kpsq_scan #(
   parameter int SCAN_DIVIDE = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tick,
   input  kpsq_pkg::req_word_type         sample,
   output logic [kpsq_pkg::MASK_BITS-1:0] pressed_mask,
   output logic signed [1:0]              step
);
   import kpsq_pkg::*;

   logic [SCAN_DIV_BITS-1:0] scan_div_ff, scan_div_in;
   logic [MASK_BITS-1:0]     latch_ff, latch_in;
   logic [3:0]               hist_ff, hist_in;
   logic [3:0]               hist_next;
   logic [SCAN_DIV_BITS-1:0] scan_div_inc;

   assign scan_div_inc = scan_div_ff + 1'b1;
   assign hist_next    = {hist_ff[1:0], sample.phase_a, sample.phase_b};
   assign hist_in      = tick ? hist_next : hist_ff;
   assign step         = STEP_LUT[hist_next];
   assign pressed_mask = latch_ff;

   always_comb begin
      scan_div_in = scan_div_ff;
      latch_in    = latch_ff;
      if (tick) begin
         scan_div_in = scan_div_inc;
         if (scan_div_inc == SCAN_DIV_BITS'(SCAN_DIVIDE)) begin
            scan_div_in = '0;
            latch_in    = {~sample.knob_switch_level, ~sample.row3_levels,
                           ~sample.row2_levels, ~sample.row1_levels};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_div_ff <= '0;
         latch_ff    <= '0;
         hist_ff     <= '0;
      end else begin
         scan_div_ff <= scan_div_in;
         latch_ff    <= latch_in;
         hist_ff     <= hist_in;
      end
   end

endmodule

// File: src/kpsq_divider.sv
module kpsq_divider #(
   parameter int WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [WIDTH-1:0]               dividend,
   input  logic [kpsq_pkg::SENS_BITS-1:0] divisor,
   output logic [WIDTH-1:0]               quotient,
   output logic                           done
);
   import kpsq_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   // restoring divide, one quotient bit per cycle; dividend shifts out
   // of the top while quotient bits shift in at the bottom
   logic [WIDTH-1:0]     dvd_ff, dvd_in;
   logic [SENS_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SENS_BITS:0]   trial;
   logic [SENS_BITS:0]   diff;
   logic                 fits;

   assign trial    = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff     = trial - {1'b0, divisor};
   assign fits     = trial >= {1'b0, divisor};
   assign quotient = dvd_ff;
   assign done     = done_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[WIDTH-2:0], fits};
         rem_in = fits ? diff[SENS_BITS-1:0] : trial[SENS_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

endmodule

// File: src/keypad_scan_and_quadrature_counter_unit.sv
// Front-panel input unit: keypad matrix latch and quadrature encoder counter.
// Request words arrive on req_valid/req_stall/req_word; an action code picks
// a tick sample, a button read or a movement read. Results leave on
// rsp_valid/rsp_stall/rsp_word from an output register, so a new request is
// taken while an earlier result still waits for the receiver.
// Ticks keep flowing back to back while a result sits in the output
// register. A button read passes its result through the result register and
// ST_EMIT into the output register. A movement read runs a bit-serial
// restoring divide of the counter magnitude by the sensitivity, one quotient
// bit per cycle, then a multiply state and a subtract state; req_stall is
// high until the result is moved into the output register.
// If the receiver stalls, the result holds in the output register; a second
// read finishes its work and then waits, stalling requests, until the first
// result is taken.
// Reset (synchronous) clears the counter, phase history, scan divider and
// button latch, empties the output register and sets the sensitivity to 4.
// The sensitivity register sits at byte address 0 of the APB-style port;
// writes of zero leave it unchanged.
module keypad_scan_and_quadrature_counter_unit #(
   parameter int SCAN_DIVIDE = 20,
   parameter int COUNT_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kpsq_pkg::req_word_type             req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kpsq_pkg::rsp_word_type             rsp_word,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [kpsq_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [kpsq_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [kpsq_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import kpsq_pkg::*;

   localparam int CB = COUNT_BITS;
   // product is at most 32768 * 255 in magnitude, which fits in 25 signed bits
   localparam int PW = 25;
   localparam int MW = (COUNT_BITS > PW) ? COUNT_BITS : PW;

   state_type                    state_ff, state_in;
   logic signed [CB-1:0]         raw_ff, raw_in;
   logic [SENS_BITS-1:0]         sens_ff, sens_in;
   logic                         neg_ff, neg_in;
   logic signed [STEPS_BITS-1:0] q_ff, q_in;
   logic signed [PW-1:0]         prod_ff, prod_in;
   rsp_word_type                 res_ff, res_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         accept;
   logic                         tick;
   logic                         div_start;
   logic                         div_done;
   logic [CB-1:0]                div_quot;
   logic [CB-1:0]                raw_mag;
   logic [MASK_BITS-1:0]         mask;
   logic signed [1:0]            step;
   logic signed [CB:0]           tick_sum;
   logic signed [MW-1:0]         sub_val;
   logic [32:0]                  qx;
   logic                         out_free;
   logic                         csr_write;

   kpsq_scan #(
      .SCAN_DIVIDE(SCAN_DIVIDE)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .sample      (req_word),
      .pressed_mask(mask),
      .step        (step)
   );

   kpsq_divider #(
      .WIDTH(CB)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(raw_mag),
      .divisor (sens_ff),
      .quotient(div_quot),
      .done    (div_done)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // magnitude of the counter; the most negative value maps to 2^(CB-1)
   assign raw_mag  = raw_ff[CB-1] ? (~raw_ff + 1'b1) : raw_ff;
   // counter minus the encoder step, one guard bit for saturation
   assign tick_sum = (CB+1)'(raw_ff) - (CB+1)'(step);
   // counter minus steps taken times sensitivity: the truncated remainder
   assign sub_val  = MW'(raw_ff) - MW'(prod_ff);
   assign qx       = 33'(div_quot);

   // APB-style register port, no wait states
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_SENS);
   assign prdata    = (paddr[2] == REG_SENS) ? CSR_DATA_BITS'(sens_ff) : '0;
   assign sens_in   = (csr_write && (pwdata[SENS_BITS-1:0] != '0)) ?
                      pwdata[SENS_BITS-1:0] : sens_ff;

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tick         = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_word.action)
                  ACT_TICK: begin
                     tick = 1'b1;
                     if (tick_sum[CB] != tick_sum[CB-1]) begin
                        // clamp to the signed counter range
                        raw_in = tick_sum[CB] ? {1'b1, {(CB-1){1'b0}}}
                                              : {1'b0, {(CB-1){1'b1}}};
                     end else begin
                        raw_in = tick_sum[CB-1:0];
                     end
                  end
                  ACT_BUTTONS: begin
                     res_in.pressed_mask   = mask;
                     res_in.movement_steps = '0;
                     state_in              = ST_EMIT;
                  end
                  ACT_MOVE: begin
                     div_start = 1'b1;
                     neg_in    = raw_ff[CB-1];
                     state_in  = ST_DIVIDE;
                  end
                  default: begin
                     // unused code: dropped
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // signed quotient, clamped to 16 bits
               if (!neg_ff && (qx > 33'd32767)) begin
                  q_in = STEPS_MAX;
               end else if (neg_ff && (qx > 33'd32768)) begin
                  q_in = STEPS_MIN;
               end else if (neg_ff) begin
                  q_in = -$signed(qx[STEPS_BITS-1:0]);
               end else begin
                  q_in = $signed(qx[STEPS_BITS-1:0]);
               end
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = PW'(q_ff) * $signed(PW'({1'b0, sens_ff}));
            state_in = ST_SUB;
         end
         ST_SUB: begin
            raw_in                = sub_val[CB-1:0];
            res_in.pressed_mask   = '0;
            res_in.movement_steps = q_ff;
            state_in              = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_word_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         raw_ff       <= '0;
         sens_ff      <= SENS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         raw_ff       <= raw_in;
         sens_ff      <= sens_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      q_ff        <= q_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: tb/sv/tb_keypad_scan_and_quadrature_counter_unit.sv
module tb_keypad_scan_and_quadrature_counter_unit;
   import kpsq_pkg::*;

   localparam int SCAN_DIVIDE   = 20;
   localparam int COUNT_BITS    = 16;
   localparam int COUNT_MAX     = (1 << (COUNT_BITS - 1)) - 1;
   localparam int COUNT_MIN     = -COUNT_MAX - 1;
   // time for a movement read to finish, with padding
   localparam int SETTLE_CYCLES = COUNT_BITS + 10;
   localparam int LONG_HOLD     = 400;
   // short forward and back walk at unit sensitivity
   localparam int SAT_TICKS     = 8;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] SENS_ADDR  = {REG_SENS, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = {~REG_SENS, 2'b00};

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_word_type             req_word;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_word_type             rsp_word;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // shared knobs for the stimulus processes
   int gap_style;          // 0: back to back on both sides, 1: random idling
   int enc_pos;            // encoder position in Gray order, 0..3
   int enc_dir;            // preferred direction of the knob in this stretch
   bit hold_off_request;   // asks the receiver for one long stall
   int rand_sens;

   // Expected-result tracker: keeps its own copy of the front-panel state and
   // queues the word that each accepted request should produce.
   class front_panel_model;
      logic [SENS_BITS-1:0]         sensitivity;
      logic [SCAN_DIV_BITS-1:0]     scan_count;
      logic [MASK_BITS-1:0]         latched_keys;
      logic [3:0]                   phase_trail;
      logic signed [COUNT_BITS-1:0] encoder_count;
      rsp_word_type                 pending_results[$];
      int                           errors;
      int                           checked;
      int                           ticks;
      int                           key_reads;
      int                           move_reads;
      int                           unused_words;
      bit                           reached_max;
      bit                           reached_min;

      function new();
         sensitivity   = SENS_RESET;
         scan_count    = '0;
         latched_keys  = '0;
         phase_trail   = '0;
         encoder_count = '0;
         errors        = 0;
         checked       = 0;
         ticks         = 0;
         key_reads     = 0;
         move_reads    = 0;
         unused_words  = 0;
         reached_max   = 0;
         reached_min   = 0;
      endfunction

      // trail is {a_old, b_old, a_new, b_new}; only the edges on A count
      function int step_of(logic [3:0] trail);
         case (trail)
            4'd2, 4'd13: return -1;
            4'd7, 4'd8:  return 1;
            default:     return 0;
         endcase
      endfunction

      function void write_register(logic index, logic [CSR_DATA_BITS-1:0] value);
         // zero, and anything outside the sensitivity register, is dropped
         if (index == REG_SENS && value[SENS_BITS-1:0] != '0)
            sensitivity = value[SENS_BITS-1:0];
      endfunction

      function void take_request(req_word_type w);
         rsp_word_type result;
         int           next_count;
         int           divisor;
         int           quotient;
         result = '0;
         case (w.action)
            ACT_TICK: begin
               ticks++;
               // key scan first, then the encoder, within the same tick
               scan_count = scan_count + 1'b1;
               if (scan_count == SCAN_DIVIDE) begin
                  scan_count   = '0;
                  latched_keys = {~w.knob_switch_level, ~w.row3_levels,
                                  ~w.row2_levels, ~w.row1_levels};
               end
               phase_trail = {phase_trail[1:0], w.phase_a, w.phase_b};
               next_count  = int'(encoder_count) - step_of(phase_trail);
               if (next_count > COUNT_MAX)
                  next_count = COUNT_MAX;
               if (next_count < COUNT_MIN)
                  next_count = COUNT_MIN;
               if (next_count == COUNT_MAX)
                  reached_max = 1;
               if (next_count == COUNT_MIN)
                  reached_min = 1;
               encoder_count = COUNT_BITS'(next_count);
            end
            ACT_BUTTONS: begin
               key_reads++;
               result.pressed_mask = latched_keys;
               pending_results.push_back(result);
            end
            ACT_MOVE: begin
               move_reads++;
               divisor  = int'(sensitivity);
               // SV division truncates toward zero, remainder stays behind
               quotient = int'(encoder_count) / divisor;
               if (quotient > int'(STEPS_MAX))
                  quotient = int'(STEPS_MAX);
               if (quotient < int'(STEPS_MIN))
                  quotient = int'(STEPS_MIN);
               encoder_count = COUNT_BITS'(int'(encoder_count) - quotient * divisor);
               result.movement_steps = STEPS_BITS'(quotient);
               pending_results.push_back(result);
            end
            default: unused_words++;
         endcase
      endfunction

      function void check_response(rsp_word_type seen);
         rsp_word_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result word with none expected (mask %h, steps %0d)",
                     $time, seen.pressed_mask, seen.movement_steps);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (seen.pressed_mask !== want.pressed_mask) begin
            $display("%0t: pressed_mask expected %h, got %h",
                     $time, want.pressed_mask, seen.pressed_mask);
            errors++;
         end
         if (seen.movement_steps !== want.movement_steps) begin
            $display("%0t: movement_steps expected %0d, got %0d",
                     $time, want.movement_steps, seen.movement_steps);
            errors++;
         end
      endfunction
   endclass

   front_panel_model panel = new();

   keypad_scan_and_quadrature_counter_unit #(
      .SCAN_DIVIDE (SCAN_DIVIDE),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_length();
      int r;
      if (gap_style == 0)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request so that the
   // output register and the divider both fill and req_stall backs up.
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n - 1) @(posedge clock);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every word taken by the receiver is checked in order.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         panel.check_response(rsp_word);
   end

   // Watchdog for a hung handshake.
   initial begin
      #10000000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [ROW_BITS-1:0] row_levels();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;        // whole row pressed
      if (r == 1)
         return '1;        // whole row released
      return ROW_BITS'($urandom_range(0, 127));
   endfunction

   function automatic logic [1:0] phase_levels(int pos);
      case (pos)
         0:       return 2'b00;
         1:       return 2'b10;
         2:       return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   // Encoder motion: mostly legal Gray steps, some rests, a few illegal jumps.
   function automatic int pick_motion();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return 2;
      if (r < 25)
         return 0;
      if (enc_dir != 0)
         return enc_dir;
      return ($urandom_range(0, 1) != 0) ? 1 : -1;
   endfunction

   function automatic req_word_type make_word(logic [1:0] act, int move);
      req_word_type w;
      w.action            = act;
      w.row1_levels       = row_levels();
      w.row2_levels       = row_levels();
      w.row3_levels       = row_levels();
      w.knob_switch_level = 1'($urandom_range(0, 1));
      if (act == ACT_TICK) begin
         enc_pos = (enc_pos + move + 4) % 4;
         {w.phase_a, w.phase_b} = phase_levels(enc_pos);
      end else begin
         {w.phase_a, w.phase_b} = 2'($urandom_range(0, 3));
      end
      return w;
   endfunction

   // Offer one word after an optional gap and hold it until accepted.
   // valid is only dropped when a gap follows, never toggled within a step.
   task automatic send_word(input req_word_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      panel.take_request(w);
   endtask

   // One APB transfer; a read is checked against the tracked sensitivity.
   task automatic csr_transfer(input bit is_write, input logic [CSR_ADDR_BITS-1:0] addr,
                               input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (is_write) begin
         panel.write_register(addr[2], data);
      end else if (prdata !== CSR_DATA_BITS'(panel.sensitivity)) begin
         $display("%0t: sensitivity readback expected %h, got %h",
                  $time, CSR_DATA_BITS'(panel.sensitivity), prdata);
         panel.errors++;
      end
   endtask

   // Registers change only with the block idle: results drained, then a
   // divide's worth of cycles so no trailing tick is still in flight.
   task automatic change_setting(input logic [CSR_ADDR_BITS-1:0] addr,
                                 input logic [CSR_DATA_BITS-1:0] data);
      req_valid <= 1'b0;
      while (panel.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_transfer(1'b1, addr, data);
      // let the bus go idle between the write and the readback
      @(posedge clock);
      csr_transfer(1'b0, SENS_ADDR, '0);
   endtask

   // Random traffic in stretches of 15 words, each with its own idling style
   // and knob direction. With pressure, a burst of reads meets a long stall.
   task automatic run_random(input int count, input bit pressure);
      int         made;
      int         r;
      logic [1:0] act;
      made = 0;
      if (pressure) begin
         hold_off_request = 1'b1;
         repeat (12)
            send_word(make_word(($urandom_range(0, 1) != 0) ? ACT_MOVE : ACT_BUTTONS, 0), 0);
         made = 12;
      end
      while (made < count) begin
         if (made % 15 == 0) begin
            gap_style = ($urandom_range(0, 2) == 0) ? 0 : 1;
            enc_dir   = int'($urandom_range(0, 2)) - 1;
         end
         r = $urandom_range(0, 99);
         if (r < 58)
            act = ACT_TICK;
         else if (r < 73)
            act = ACT_BUTTONS;
         else if (r < 96)
            act = ACT_MOVE;
         else
            act = ACT_UNUSED;
         send_word(make_word(act, pick_motion()), idle_length());
         if (act != ACT_UNUSED)
            made++;
      end
   endtask

   initial begin
      req_word_type w;
      int           i;
      int           waited;
      gap_style        = 1;
      enc_pos          = 0;
      enc_dir          = 0;
      hold_off_request = 1'b0;
      reset   <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reads straight out of reset, ignored action code
      send_word(make_word(ACT_BUTTONS, 0), 0);
      send_word(make_word(ACT_MOVE, 0), 0);
      send_word(make_word(ACT_UNUSED, 0), idle_length());
      // one full scan period with every key and the knob switch held down,
      // while the knob turns forward
      for (i = 0; i < SCAN_DIVIDE; i++) begin
         w = make_word(ACT_TICK, 1);
         w.row1_levels       = '0;
         w.row2_levels       = '0;
         w.row3_levels       = '0;
         w.knob_switch_level = 1'b0;
         send_word(w, idle_length());
      end
      send_word(make_word(ACT_BUTTONS, 0), idle_length());
      send_word(make_word(ACT_MOVE, 0), idle_length());
      // turn back far enough for a negative quotient with a remainder
      for (i = 0; i < 16; i++)
         send_word(make_word(ACT_TICK, -1), idle_length());
      send_word(make_word(ACT_MOVE, 0), idle_length());

      // --- unit sensitivity; walk the counter forward, then back
      change_setting(SENS_ADDR, 32'd1);
      gap_style = 0;
      for (i = 0; i < SAT_TICKS; i++)
         send_word(make_word(ACT_TICK, 1), 0);
      send_word(make_word(ACT_BUTTONS, 0), 0);
      send_word(make_word(ACT_MOVE, 0), 0);
      for (i = 0; i < SAT_TICKS; i++)
         send_word(make_word(ACT_TICK, -1), 0);
      send_word(make_word(ACT_MOVE, 0), 0);
      gap_style = 1;
      run_random(55, 1'b0);

      // --- largest sensitivity
      change_setting(SENS_ADDR, 32'd255);
      run_random(55, 1'b0);

      // --- zero write is dropped; long receiver hold-off here
      change_setting(SENS_ADDR, 32'd0);
      run_random(55, 1'b1);

      // --- write to the unused register slot is dropped
      change_setting(SPARE_ADDR, 32'd9);
      run_random(55, 1'b0);

      // --- bits above the register width are dropped
      change_setting(SENS_ADDR, 32'h0000_0103);
      run_random(55, 1'b0);

      rand_sens = $urandom_range(2, 254);
      change_setting(SENS_ADDR, CSR_DATA_BITS'(rand_sens));
      run_random(55, 1'b0);

      change_setting(SENS_ADDR, 32'd128);
      run_random(60, 1'b0);

      // --- drain, then give a divide's worth of cycles for strays
      req_valid <= 1'b0;
      waited = 0;
      while (panel.pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (panel.pending_results.size() != 0) begin
         $display("%0t: %0d expected result words never arrived",
                  $time, panel.pending_results.size());
         panel.errors++;
      end

      $display("Run covered %0d ticks, %0d key reads, %0d movement reads, %0d unused words;",
               panel.ticks, panel.key_reads, panel.move_reads, panel.unused_words);
      $display("%0d result words checked, sensitivity 1/3/128/255/%0d, limits hit %0b/%0b.",
               panel.checked, rand_sens, panel.reached_max, panel.reached_min);
      if (panel.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
